FILE: rtl/core/bbm_pkg.sv
// ----------------------------------------------------------------------------
// bbm_pkg - shared types for the backward brace matcher
// Status codes, brace codes and the classified-beat record passed from the
// front end to the stack engine.
// ----------------------------------------------------------------------------
package bbm_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_SEARCH    = 3'd1,
        ST_FOUND     = 3'd2,
        ST_LIMIT     = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_BAD_START = 3'd5
    } bbm_status_t;

    // Brace kind: round, square, curly
    typedef enum logic [1:0] {
        BR_ROUND  = 2'd0,
        BR_SQUARE = 2'd1,
        BR_CURLY  = 2'd2,
        BR_NONE   = 2'd3
    } bbm_brace_t;

    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // ')'
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ']'
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // '}'
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // '('
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // '['
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // '{'

    localparam int unsigned     BYTES_W   = 17;
    localparam logic [16:0]     BYTES_MAX = 17'h1FFFF;

    // Decoupling queue between front end and engine
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified text beat
    typedef struct packed {
        logic       start;     // begins a new search
        logic       skip;      // byte in comment or string
        bbm_brace_t close_br;  // closing brace kind, BR_NONE if not one
        bbm_brace_t open_br;   // opening brace kind, BR_NONE if not one
    } bbm_item_t;

endpackage

FILE: rtl/core/bbm_front.sv
// ----------------------------------------------------------------------------
// bbm_front - input front end
// Takes text beats, decodes the byte into brace classes and holds the
// result in a two-entry queue for the stack engine.
// ----------------------------------------------------------------------------
module bbm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               start_req,
    input  logic [7:0]         char_in,
    input  logic               in_comment_or_string,
    output logic               q_valid,
    output bbm_pkg::bbm_item_t q_item,
    input  logic               q_pop
);

    localparam int unsigned PW = $clog2(bbm_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(bbm_pkg::QUEUE_DEPTH + 1);

    bbm_pkg::bbm_item_t item;
    bbm_pkg::bbm_item_t queue_reg [bbm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               push;

    // byte decode
    always_comb
    begin
        item.start = start_req;
        item.skip  = in_comment_or_string;
        case (char_in)
            bbm_pkg::CH_CLOSE_ROUND:  item.close_br = bbm_pkg::BR_ROUND;
            bbm_pkg::CH_CLOSE_SQUARE: item.close_br = bbm_pkg::BR_SQUARE;
            bbm_pkg::CH_CLOSE_CURLY:  item.close_br = bbm_pkg::BR_CURLY;
            default:                  item.close_br = bbm_pkg::BR_NONE;
        endcase
        case (char_in)
            bbm_pkg::CH_OPEN_ROUND:   item.open_br = bbm_pkg::BR_ROUND;
            bbm_pkg::CH_OPEN_SQUARE:  item.open_br = bbm_pkg::BR_SQUARE;
            bbm_pkg::CH_OPEN_CURLY:   item.open_br = bbm_pkg::BR_CURLY;
            default:                  item.open_br = bbm_pkg::BR_NONE;
        endcase
    end

    assign in_stall = (count_reg == CW'(bbm_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(bbm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(bbm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PW'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

    // assertions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(bbm_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> count_reg != '0)
        else $error("queue empty after push");

endmodule

FILE: rtl/core/bbm_back.sv
// ----------------------------------------------------------------------------
// bbm_back - brace stack engine
// Runs one classified beat per cycle, while the output is not stalled, against
// the brace stack and posts the status into the output register. Top two
// entries live in flip-flops, the rest in a memory whose registered read
// always holds the third entry.
module bbm_back
#(
    parameter int unsigned STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               q_valid,
    input  bbm_pkg::bbm_item_t q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

    logic [15:0]               limit_reg;
    logic                      active_reg, active_next;
    logic [LW-1:0]             lvl_reg, lvl_next;
    logic [1:0]                top_reg, top_next;
    logic [1:0]                second_reg, second_next;
    logic [bbm_pkg::BYTES_W-1:0] bytes_reg, bytes_next, bytes_inc;
    logic                      out_valid_reg;
    bbm_pkg::bbm_status_t      status_reg, status_next;
    logic [1:0]                stack_mem [STACK_DEPTH];
    logic [1:0]                rd_reg;
    logic                      mem_we;
    logic [AW-1:0]             waddr, raddr;
    logic [LW-1:0]             lvl_after;
    logic                      go;

    assign go        = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = go;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    assign bytes_inc = (bytes_reg == bbm_pkg::BYTES_MAX) ? bytes_reg
                                                         : bytes_reg + 17'd1;
    assign waddr = AW'(lvl_reg - LW'(2));
    assign raddr = AW'(lvl_next - LW'(3));

    always_comb
    begin
        active_next = active_reg;
        lvl_next    = lvl_reg;
        top_next    = top_reg;
        second_next = second_reg;
        bytes_next  = bytes_reg;
        status_next = bbm_pkg::ST_IDLE;
        mem_we      = 1'b0;
        lvl_after   = lvl_reg;
        if (go)
        begin
            if (q_item.start)
            begin
                if (q_item.close_br == bbm_pkg::BR_NONE)
                begin
                    active_next = 1'b0;
                    status_next = bbm_pkg::ST_BAD_START;
                end
                else
                begin
                    top_next    = q_item.close_br;
                    lvl_next    = LW'(1);
                    bytes_next  = '0;
                    active_next = 1'b1;
                    status_next = bbm_pkg::ST_SEARCH;
                end
            end
            else if (active_reg)
            begin
                bytes_next = bytes_inc;
                if ((limit_reg != '0) && (bytes_inc > {1'b0, limit_reg}))
                begin
                    active_next = 1'b0;
                    status_next = bbm_pkg::ST_LIMIT;
                end
                else if (q_item.skip)
                begin
                    status_next = bbm_pkg::ST_SEARCH;
                end
                else if (q_item.close_br != bbm_pkg::BR_NONE)
                begin
                    if (lvl_reg >= LW'(STACK_DEPTH))
                    begin
                        active_next = 1'b0;
                        status_next = bbm_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // push: old second spills to memory
                        mem_we      = (lvl_reg >= LW'(2));
                        second_next = top_reg;
                        top_next    = q_item.close_br;
                        lvl_next    = lvl_reg + LW'(1);
                        status_next = bbm_pkg::ST_SEARCH;
                    end
                end
                else
                begin
                    if ((lvl_reg != '0) && (q_item.open_br == top_reg))
                    begin
                        // pop: third entry comes up from the read register
                        lvl_after   = lvl_reg - LW'(1);
                        lvl_next    = lvl_after;
                        top_next    = second_reg;
                        second_next = rd_reg;
                    end
                    if (lvl_after == '0)
                    begin
                        active_next = 1'b0;
                        status_next = bbm_pkg::ST_FOUND;
                    end
                    else
                    begin
                        status_next = bbm_pkg::ST_SEARCH;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            active_reg    <= 1'b0;
            lvl_reg       <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            active_reg <= active_next;
            lvl_reg    <= lvl_next;
            bytes_reg  <= bytes_next;
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        second_reg <= second_next;
        if (go)
        begin
            status_reg <= status_next;
        end
    end

    // stack memory, write-through on same address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[waddr] <= second_reg;
        end
        rd_reg <= (mem_we && (waddr == raddr)) ? second_reg : stack_mem[raddr];
    end

    // assertions
    a_active_level: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> lvl_reg != '0)
        else $error("active search with empty stack");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_go_loads: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("executed beat not posted");

    a_start_level: assert property (@(posedge clk) disable iff (!rst_n)
        go && q_item.start && q_item.close_br != bbm_pkg::BR_NONE
        |=> lvl_reg == LW'(1) && active_reg)
        else $error("start did not load stack");

endmodule

FILE: rtl/core/backward_brace_matcher.sv
// ----------------------------------------------------------------------------
// backward_brace_matcher - brace matcher for a backward text walk
// Finds the opening brace matching a given closing brace from bytes that
// arrive nearest first.
// ----------------------------------------------------------------------------
// Usage: send a start beat (start_req=1) with ')', ']' or '}' in char_in,
// then the preceding text one byte per beat, walking backward, with
// in_comment_or_string set for bytes to be skipped. Every input beat gives
// exactly one status beat: 1 searching, 2 found, 3 limit exceeded,
// 4 stack overflow, 5 bad start, 0 for bytes outside a search. One byte is
// taken per clock while in_stall is low; the result passes through the queue
// and then the stack engine's output register. The engine's stack update
// sets the rate: the top two stack entries sit in flip-flops and the memory
// read for the third is addressed from the next stack level and registered.
// scan_limit is written via cfg_we/cfg_data while idle; 0 means unlimited.
// Stack storage is STACK_DEPTH entries and needs no clearing after reset.
// ----------------------------------------------------------------------------
module backward_brace_matcher
#(
    parameter int unsigned STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    // input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_req,
    input  logic [7:0]  char_in,
    input  logic        in_comment_or_string,
    // result beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status
);

    logic               q_valid;
    logic               q_pop;
    bbm_pkg::bbm_item_t q_item;

    // front end: decode and queue
    bbm_front u_front
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .start_req            (start_req),
        .char_in              (char_in),
        .in_comment_or_string (in_comment_or_string),
        .q_valid              (q_valid),
        .q_item               (q_item),
        .q_pop                (q_pop)
    );

    // back end: stack engine and output register
    bbm_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

endmodule

FILE: tb/sv/backward_brace_matcher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backward_brace_matcher_test - self-checking bench for the brace matcher
// Drives a short table of hand-picked beats, then random backward text walks
// (balanced searches, deep nests, noise, restarts) under several scan limits.
// Every status beat is checked against a written-down value or an in-bench model.
// ----------------------------------------------------------------------------
module backward_brace_matcher_test;

    localparam int STK_DEPTH      = 64;
    localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up
    localparam int RANDOM_BEATS   = 1450;  // live beats in the random part
    localparam int N_PHASES       = 8;
    localparam int LONG_HOLD      = 150;   // receiver hold-off, in cycles

    // One row of the directed table. typed_in marks rows whose status is
    // written down here; the rest take the model's answer.
    typedef struct packed {
        logic                 start;
        logic [7:0]           ch;
        logic                 skip;
        logic                 typed_in;
        bbm_pkg::bbm_status_t want;
    } table_row_t;

    localparam int N_ROWS = 21;
    localparam table_row_t DIRECTED [N_ROWS] = '{
        '{1'b0, 8'h78,                    1'b0, 1'b1, bbm_pkg::ST_IDLE}, // byte after reset
        '{1'b1, 8'h00,                    1'b0, 1'b1, bbm_pkg::ST_BAD_START}, // lowest byte
        '{1'b1, 8'hFF,                    1'b1, 1'b1, bbm_pkg::ST_BAD_START}, // highest byte
        '{1'b0, 8'hFF,                    1'b1, 1'b1, bbm_pkg::ST_IDLE},
        '{1'b1, bbm_pkg::CH_CLOSE_ROUND,  1'b0, 1'b1, bbm_pkg::ST_SEARCH},
        '{1'b0, bbm_pkg::CH_OPEN_ROUND,   1'b0, 1'b1, bbm_pkg::ST_FOUND},
        '{1'b0, bbm_pkg::CH_OPEN_ROUND,   1'b0, 1'b1, bbm_pkg::ST_IDLE}, // byte after the end
        '{1'b1, bbm_pkg::CH_CLOSE_SQUARE, 1'b0, 1'b1, bbm_pkg::ST_SEARCH},
        '{1'b0, bbm_pkg::CH_OPEN_ROUND,   1'b0, 1'b0, bbm_pkg::ST_IDLE}, // wrong opener
        '{1'b0, bbm_pkg::CH_OPEN_SQUARE,  1'b1, 1'b0, bbm_pkg::ST_IDLE}, // partner in a string
        '{1'b0, bbm_pkg::CH_CLOSE_ROUND,  1'b1, 1'b0, bbm_pkg::ST_IDLE}, // closer in a comment
        '{1'b0, bbm_pkg::CH_OPEN_SQUARE,  1'b0, 1'b0, bbm_pkg::ST_IDLE},
        '{1'b1, bbm_pkg::CH_CLOSE_CURLY,  1'b0, 1'b1, bbm_pkg::ST_SEARCH},
        '{1'b0, bbm_pkg::CH_CLOSE_ROUND,  1'b0, 1'b0, bbm_pkg::ST_IDLE}, // nested push
        '{1'b0, 8'h00,                    1'b0, 1'b0, bbm_pkg::ST_IDLE},
        '{1'b0, bbm_pkg::CH_OPEN_ROUND,   1'b0, 1'b0, bbm_pkg::ST_IDLE}, // pop back to curly
        '{1'b1, bbm_pkg::CH_CLOSE_ROUND,  1'b0, 1'b0, bbm_pkg::ST_IDLE}, // restart mid-search
        '{1'b1, 8'h61,                    1'b0, 1'b1, bbm_pkg::ST_BAD_START}, // kills search
        '{1'b0, bbm_pkg::CH_OPEN_ROUND,   1'b0, 1'b1, bbm_pkg::ST_IDLE},
        '{1'b1, bbm_pkg::CH_CLOSE_CURLY,  1'b1, 1'b1, bbm_pkg::ST_SEARCH},
        '{1'b0, bbm_pkg::CH_OPEN_CURLY,   1'b0, 1'b1, bbm_pkg::ST_FOUND}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        start_req = 1'b0;
    logic [7:0]  char_in = '0;
    logic        in_comment_or_string = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [2:0]  status;

    // Model state
    bbm_pkg::bbm_brace_t  brace_stk [STK_DEPTH];
    int                   depth;
    logic [16:0]          scanned;
    logic                 srch_on;
    logic [15:0]          scan_lim;

    bbm_pkg::bbm_status_t status_due [$];   // statuses still owed by the block
    int                   error_count;
    int                   live_beats;       // beats that did something (not idle)
    bit                   tx_idle;
    bit                   rx_idle;
    bit                   hold_long;

    backward_brace_matcher #(.STACK_DEPTH(STK_DEPTH)) i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .start_req            (start_req),
        .char_in              (char_in),
        .in_comment_or_string (in_comment_or_string),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status)
    );

    always #5 clk = ~clk;

    function automatic bbm_pkg::bbm_brace_t kind_of_closer(input logic [7:0] c);
        case (c)
            bbm_pkg::CH_CLOSE_ROUND:  return bbm_pkg::BR_ROUND;
            bbm_pkg::CH_CLOSE_SQUARE: return bbm_pkg::BR_SQUARE;
            bbm_pkg::CH_CLOSE_CURLY:  return bbm_pkg::BR_CURLY;
            default:                  return bbm_pkg::BR_NONE;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input bbm_pkg::bbm_brace_t kind);
        case (kind)
            bbm_pkg::BR_ROUND:  return bbm_pkg::CH_CLOSE_ROUND;
            bbm_pkg::BR_SQUARE: return bbm_pkg::CH_CLOSE_SQUARE;
            default:            return bbm_pkg::CH_CLOSE_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] opener_char(input bbm_pkg::bbm_brace_t kind);
        case (kind)
            bbm_pkg::BR_ROUND:  return bbm_pkg::CH_OPEN_ROUND;
            bbm_pkg::BR_SQUARE: return bbm_pkg::CH_OPEN_SQUARE;
            default:            return bbm_pkg::CH_OPEN_CURLY;
        endcase
    endfunction

    // Advances the model by one input beat and gives the status it owes.
    function automatic bbm_pkg::bbm_status_t predict_status(input logic s,
                                                            input logic [7:0] c,
                                                            input logic k);
        bbm_pkg::bbm_brace_t shut;
        shut = kind_of_closer(c);
        if (s)
        begin
            if (shut == bbm_pkg::BR_NONE)
            begin
                srch_on = 1'b0;
                return bbm_pkg::ST_BAD_START;
            end
            brace_stk[0] = shut;
            depth = 1;
            scanned = '0;
            srch_on = 1'b1;
            return bbm_pkg::ST_SEARCH;
        end
        if (!srch_on)
            return bbm_pkg::ST_IDLE;

        // limit is checked before the comment test, so skipped bytes count
        if (scanned != bbm_pkg::BYTES_MAX)
            scanned = scanned + 17'd1;
        if (scan_lim != 16'd0 && scanned > {1'b0, scan_lim})
        begin
            srch_on = 1'b0;
            return bbm_pkg::ST_LIMIT;
        end
        if (k)
            return bbm_pkg::ST_SEARCH;

        if (shut != bbm_pkg::BR_NONE)
        begin
            if (depth >= STK_DEPTH)
            begin
                srch_on = 1'b0;
                return bbm_pkg::ST_OVERFLOW;
            end
            brace_stk[depth] = shut;
            depth++;
            return bbm_pkg::ST_SEARCH;
        end
        // only the partner of the top brace pops; other openers are ignored
        if (depth > 0 && c == opener_char(brace_stk[depth-1]))
            depth--;
        if (depth == 0)
        begin
            srch_on = 1'b0;
            return bbm_pkg::ST_FOUND;
        end
        return bbm_pkg::ST_SEARCH;
    endfunction

    // Offers one beat, after a random gap when tx_idle is set, and books its
    // status once taken. Valid is left high after acceptance so back-to-back
    // beats never see a low and a high drive in the same step.
    task automatic send_beat(input logic s, input logic [7:0] c, input logic k,
                             input logic typed_in, input bbm_pkg::bbm_status_t want);
        int                   gap;
        bbm_pkg::bbm_status_t got;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid             <= 1'b1;
        start_req            <= s;
        char_in              <= c;
        in_comment_or_string <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = predict_status(s, c, k);
        status_due.push_back(typed_in ? want : got);
        if (got != bbm_pkg::ST_IDLE)
            live_beats++;
    endtask

    // Sender stops, waits for every owed status, then writes the limit.
    task automatic settle_and_configure(input logic [15:0] lim);
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        scan_lim = lim;
        cfg_we <= 1'b0;
    endtask

    // One backward walk from a random closing brace. plan mirrors what the
    // text has opened so far and steers the walk towards a match; pushes
    // are weighted by push_pct so deep walks run into the stack bound.
    task automatic walk_search(input int depth_cap, input int len_cap, input int push_pct);
        bbm_pkg::bbm_brace_t plan [$];
        bbm_pkg::bbm_brace_t kind;
        logic [7:0]          b;
        int                  n;
        int                  pick;
        kind = bbm_pkg::bbm_brace_t'($urandom_range(0, 2));
        plan.push_back(kind);
        send_beat(1'b1, closer_char(kind), 1'($urandom_range(0, 1)), 1'b0,
                  bbm_pkg::ST_IDLE);
        n = 0;
        while (plan.size() != 0 && srch_on)
        begin
            pick = $urandom_range(0, 99);
            if (n >= len_cap)
            begin
                // close out whatever is left
                send_beat(1'b0, opener_char(plan[$]), 1'b0, 1'b0, bbm_pkg::ST_IDLE);
                void'(plan.pop_back());
            end
            else if (pick < push_pct && plan.size() < depth_cap)
            begin
                kind = bbm_pkg::bbm_brace_t'($urandom_range(0, 2));
                plan.push_back(kind);
                send_beat(1'b0, closer_char(kind), 1'b0, 1'b0, bbm_pkg::ST_IDLE);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    // anything at all inside a comment or string
                    send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0,
                              bbm_pkg::ST_IDLE);
                end
                else if (pick < 45)
                begin
                    kind = bbm_pkg::bbm_brace_t'((int'(plan[$]) + $urandom_range(1, 2)) % 3);
                    send_beat(1'b0, opener_char(kind), 1'b0, 1'b0, bbm_pkg::ST_IDLE);
                end
                else if (pick < 70)
                begin
                    b = 8'($urandom_range(0, 255));
                    send_beat(1'b0, b, 1'b0, 1'b0, bbm_pkg::ST_IDLE);
                    if (kind_of_closer(b) != bbm_pkg::BR_NONE)
                        plan.push_back(kind_of_closer(b));
                    else if (b == opener_char(plan[$]))
                        void'(plan.pop_back());
                end
                else if (pick < 73)
                begin
                    // fresh start in the middle of a walk
                    send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0, bbm_pkg::ST_IDLE);
                    plan.delete();
                end
                else
                begin
                    send_beat(1'b0, opener_char(plan[$]), 1'b0, 1'b0, bbm_pkg::ST_IDLE);
                    void'(plan.pop_back());
                end
            end
            n++;
        end
    endtask

    // Receiver: random hold-off per beat when rx_idle is set, one long hold-off on request.
    initial
    begin
        int                   hold;
        bbm_pkg::bbm_status_t due;
        forever
        begin
            if (hold_long)
            begin
                hold = LONG_HOLD;
                hold_long = 1'b0;
            end
            else
            begin
                hold = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            // valid is unknown until the first edge in reset
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (status_due.size() == 0)
            begin
                error_count++;
                $display("%0t: status beat %0d with nothing expected", $time, status);
            end
            else
            begin
                due = status_due.pop_front();
                if (status !== 3'(due))
                begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, due, status);
                end
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [15:0] lim;
        int          p;
        int          pick;
        depth       = 0;
        scanned     = '0;
        srch_on     = 1'b0;
        scan_lim    = '0;
        error_count = 0;
        live_beats  = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_long   = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, scan limit still at its reset value of zero
        for (int r = 0; r < N_ROWS; r++)
            send_beat(DIRECTED[r].start, DIRECTED[r].ch, DIRECTED[r].skip,
                      DIRECTED[r].typed_in, DIRECTED[r].want);

        live_beats = 0;
        for (p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0, 4, 7: lim = 16'd0;
                1:       lim = 16'hFFFF;
                2:       lim = 16'd1;
                3:       lim = 16'd2;
                5:       lim = 16'($urandom_range(3, 30));
                default: lim = 16'($urandom_range(0, 65535));
            endcase
            settle_and_configure(lim);

            // phase 4 is the fill-up test: sender flat out, receiver holds off
            tx_idle = (p % 3 != 1) && (p != 4);
            rx_idle = (p % 4 != 3);
            if (p == 4)
                hold_long = 1'b1;

            while (live_beats < (p + 1) * RANDOM_BEATS / N_PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    walk_search(STK_DEPTH + 6, 300, 85);
                else if (pick < 20)
                    send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0, bbm_pkg::ST_IDLE);
                else
                    walk_search($urandom_range(1, 8), 40, 35);
            end
        end

        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
